// File: hw/rtl/rc_satellite_frame_decoder_macros.svh
// ----------------------------------------------------------------------------
// RC satellite frame decoder assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RC_SATELLITE_FRAME_DECODER_MACROS_SVH
`define RC_SATELLITE_FRAME_DECODER_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define RCSFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define RCSFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rcsfd_pkg.sv
// ----------------------------------------------------------------------------
// RC satellite frame decoder package
// Shared function codes, register indexes, field widths, reset values and decoded-word type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcsfd_pkg;

  // Item function codes carried in the input tuser
  typedef enum logic [1:0] {
    FUNC_BYTE     = 2'd0,
    FUNC_TICK     = 2'd1,
    FUNC_FS_WRITE = 2'd2
  } func_e;

  // Configuration register indexes
  localparam logic [7:0] CFG_MODE_2048 = 8'd0;
  localparam logic [7:0] CFG_FS_TIMEOUT = 8'd1;

  // Field widths
  localparam int unsigned IdW  = 4;
  localparam int unsigned PosW = 11;
  localparam int unsigned MsW  = 16;

  // Reset values
  localparam logic [MsW-1:0] MsReset      = 16'hFFFF;
  localparam logic [MsW-1:0] TimeoutReset = 16'd1000;

  // One decoded servo word
  typedef struct packed {
    logic            valid;
    logic [IdW-1:0]  channel;
    logic [PosW-1:0] value;
  } word_t;

endpackage

`default_nettype wire

// File: hw/rtl/rcsfd_word_dec.sv
// ----------------------------------------------------------------------------
// RC satellite frame decoder servo word split
// Splits a 16-bit servo word into channel id and position by field mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcsfd_word_dec #(
  parameter int unsigned Channels = 16
) (
  input  wire logic [15:0]          word_i,
  input  wire logic                 mode_2048_i,
  output rcsfd_pkg::word_t          word_o
);

  logic [rcsfd_pkg::IdW-1:0]  id;
  logic [rcsfd_pkg::PosW-1:0] pos;
  logic                       in_range;

  // Pick id and position fields for the selected mode
  always_comb begin
    if (mode_2048_i) begin
      id  = word_i[14:11];
      pos = word_i[10:0];
    end else begin
      id  = word_i[13:10];
      pos = {1'b0, word_i[9:0]};
    end
    in_range = ({1'b0, id} < 5'(Channels));
  end

  // Zero the fields of a word with an unknown channel
  always_comb begin
    word_o.valid   = in_range;
    word_o.channel = in_range ? id : '0;
    word_o.value   = in_range ? pos : '0;
  end

endmodule

`default_nettype wire

// File: hw/rtl/rc_satellite_frame_decoder.sv
// Path: input transfer to result through the input register, then the result register.
// Throughput: one item per cycle while the result side is ready; the state update and table query fit in one
//   stage between the input register and the result register.
// Reset: asynchronous, active low; clears both tables, the byte position and high
//   byte, sets the frame timer to all ones (failsafe active), mode 2048, timeout 1000.
// ----------------------------------------------------------------------------
// RC satellite frame decoder
// Pairs frame bytes into servo words, keeps live and failsafe channel tables,
// times frame loss in millisecond ticks and answers one channel query per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rc_satellite_frame_decoder_macros.svh"

module rc_satellite_frame_decoder #(
  parameter int unsigned FRAME_BYTES = 16,
  parameter int unsigned CHANNELS    = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: rx_byte[7:0], channel_index[11:8], failsafe_value[22:12], zero pad
  input  wire logic [23:0] s_axis_tdata,
  // tuser: func[1:0], frame_start[2]
  input  wire logic [2:0]  s_axis_tuser,
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: query_value[10:0], word_channel[14:11], word_value[25:15], zero pad
  output logic [31:0]      m_axis_tdata,
  // tuser: failsafe_active[0], word_valid[1]
  output logic [1:0]       m_axis_tuser,
  // Configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned BpW  = $clog2(FRAME_BYTES);
  localparam int unsigned ChW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IdW  = rcsfd_pkg::IdW;
  localparam int unsigned PosW = rcsfd_pkg::PosW;
  localparam int unsigned MsW  = rcsfd_pkg::MsW;

  // Configuration registers
  logic           mode_2048_q;
  logic [MsW-1:0] timeout_q;

  // Input register
  logic                  in_valid_q;
  rcsfd_pkg::func_e      func_q;
  logic                  start_q;
  logic [7:0]            rx_byte_q;
  logic [IdW-1:0]        ch_idx_q;
  logic [PosW-1:0]       fs_val_q;

  // Decoder state
  logic [BpW-1:0]  byte_pos_q, byte_pos_d;
  logic [7:0]      high_byte_q, high_byte_d;
  logic [MsW-1:0]  ms_q, ms_d;
  logic [PosW-1:0] chan_tab_q [CHANNELS];
  logic [PosW-1:0] fs_tab_q   [CHANNELS];

  // Result register
  logic            out_valid_q;
  logic [PosW-1:0] query_q, query_d;
  logic            fs_act_q, fs_act_d;
  rcsfd_pkg::word_t word_q, word_d;

  logic             commit;
  logic [BpW-1:0]   pos_cur;
  logic [BpW:0]     pos_next;
  logic             frame_end;
  logic             word_done;
  logic             tab_wr;
  logic             fs_wr;
  logic             ch_in_range;
  logic [ChW-1:0]   ch_sel;
  logic [ChW-1:0]   wr_sel;
  logic [PosW-1:0]  chan_rd;
  logic [PosW-1:0]  fs_rd;
  rcsfd_pkg::word_t dec_word;

  // Handshakes: the result register drains while the input register refills
  assign commit        = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || commit;
  assign cfg_ready_o   = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_2048_q <= 1'b1;
      timeout_q   <= rcsfd_pkg::TimeoutReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcsfd_pkg::CFG_MODE_2048:  mode_2048_q <= cfg_data_i[0];
        rcsfd_pkg::CFG_FS_TIMEOUT: timeout_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture an input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      func_q    <= rcsfd_pkg::func_e'(s_axis_tuser[1:0]);
      start_q   <= s_axis_tuser[2];
      rx_byte_q <= s_axis_tdata[7:0];
      ch_idx_q  <= s_axis_tdata[11:8];
      fs_val_q  <= s_axis_tdata[22:12];
    end
  end

  // Split the word formed by the held high byte and this byte
  rcsfd_word_dec #(
    .Channels (CHANNELS)
  ) u_word_dec (
    .word_i      ({high_byte_q, rx_byte_q}),
    .mode_2048_i (mode_2048_q),
    .word_o      (dec_word)
  );

  // Byte position and frame end
  assign pos_cur   = start_q ? '0 : byte_pos_q;
  assign pos_next  = {1'b0, pos_cur} + (BpW+1)'(1);
  assign frame_end = (pos_next >= (BpW+1)'(FRAME_BYTES));
  assign word_done = pos_cur[0] && (pos_cur != BpW'(1));

  assign ch_in_range = ({1'b0, ch_idx_q} < 5'(CHANNELS));
  assign ch_sel      = ch_idx_q[ChW-1:0];
  assign wr_sel      = dec_word.channel[ChW-1:0];

  // Next state for one item
  always_comb begin
    byte_pos_d  = byte_pos_q;
    high_byte_d = high_byte_q;
    ms_d        = ms_q;
    word_d      = '0;
    tab_wr      = 1'b0;
    fs_wr       = 1'b0;
    case (func_q)
      rcsfd_pkg::FUNC_BYTE: begin
        if (!pos_cur[0]) begin
          high_byte_d = rx_byte_q;
        end else if (word_done) begin
          word_d = dec_word;
          tab_wr = dec_word.valid;
        end
        if (frame_end) begin
          byte_pos_d = '0;
          ms_d       = '0;
        end else begin
          byte_pos_d = pos_next[BpW-1:0];
        end
      end
      rcsfd_pkg::FUNC_TICK: begin
        if (ms_q != rcsfd_pkg::MsReset) begin
          ms_d = ms_q + MsW'(1);
        end
      end
      rcsfd_pkg::FUNC_FS_WRITE: begin
        fs_wr = ch_in_range;
      end
      default: ;
    endcase
  end

  // Query after this item's update, bypassing table writes of the same item
  always_comb begin
    chan_rd  = (tab_wr && (dec_word.channel == ch_idx_q)) ? dec_word.value
                                                          : chan_tab_q[ch_sel];
    fs_rd    = fs_wr ? fs_val_q : fs_tab_q[ch_sel];
    fs_act_d = (ms_d > timeout_q);
    if (!ch_in_range) begin
      query_d = '0;
    end else begin
      query_d = fs_act_d ? fs_rd : chan_rd;
    end
  end

  // Advance decoder state and tables on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= '0;
      high_byte_q <= '0;
      ms_q        <= rcsfd_pkg::MsReset;
      for (int i = 0; i < int'(CHANNELS); i++) begin
        chan_tab_q[i] <= '0;
        fs_tab_q[i]   <= '0;
      end
    end else if (commit) begin
      byte_pos_q  <= byte_pos_d;
      high_byte_q <= high_byte_d;
      ms_q        <= ms_d;
      if (tab_wr) begin
        chan_tab_q[wr_sel] <= dec_word.value;
      end
      if (fs_wr) begin
        fs_tab_q[ch_sel] <= fs_val_q;
      end
    end
  end

  // Result register: load on commit, drop on output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      query_q  <= query_d;
      fs_act_q <= fs_act_d;
      word_q   <= word_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, word_q.value, word_q.channel, query_q};
  assign m_axis_tuser  = {word_q.valid, fs_act_q};

  // Checks
  `RCSFD_ASSERT_NXT(a_in_held, in_valid_q && !commit, in_valid_q,
    "input item dropped while stalled")
  `RCSFD_ASSERT_NXT(a_frame_end_clears, commit && (func_q == rcsfd_pkg::FUNC_BYTE) && frame_end,
    (ms_q == '0) && !m_axis_tuser[0], "frame end did not clear the frame timer")
  `RCSFD_ASSERT_IMP(a_word_zero, m_axis_tvalid && !m_axis_tuser[1],
    m_axis_tdata[25:11] == '0, "word fields not zero without a valid word")

endmodule

`default_nettype wire

// File: bench/rc_satellite_frame_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC satellite frame decoder testbench
// Streams received bytes, millisecond ticks and failsafe writes into the
// decoder and checks every result transfer against a cycle-free predictor
// of the frame decoder, over several mode and timeout settings and under
// random stalls on both stream sides.
// ----------------------------------------------------------------------------

module rc_satellite_frame_decoder_tb;

  localparam int unsigned FRAME_BYTES = 16;
  localparam int unsigned CHANNELS    = 16;
  localparam time         ClkHigh     = 6ns;
  localparam time         ClkLow      = 6ns;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PhaseItems  = 165;
  localparam int unsigned NumPhases   = 6;

  // Function code that the package leaves unnamed; the block must ignore it
  localparam logic [1:0] FuncUnused = 2'd3;

  // Expected content of one result transfer
  typedef struct {
    logic [rcsfd_pkg::PosW-1:0] query_value;
    logic                       failsafe_active;
    rcsfd_pkg::word_t           word;
  } decoder_out_t;

  // --------------------------------------------------------------------------
  // Frame decoder predictor and result store
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic                       mode_2048;
    logic [rcsfd_pkg::MsW-1:0]  timeout_ms;
    int unsigned                byte_pos;
    logic [7:0]                 high_byte;
    logic [rcsfd_pkg::PosW-1:0] live_tbl [CHANNELS];
    logic [rcsfd_pkg::PosW-1:0] fs_tbl [CHANNELS];
    logic [rcsfd_pkg::MsW-1:0]  ms_since;
    decoder_out_t               expected_q [$];
    int unsigned                err_cnt;
    int unsigned                result_cnt;
    int unsigned                word_cnt;
    int unsigned                fs_result_cnt;

    function new();
      mode_2048  = 1'b1;
      timeout_ms = rcsfd_pkg::TimeoutReset;
      byte_pos   = 0;
      high_byte  = '0;
      ms_since   = rcsfd_pkg::MsReset;
      for (int i = 0; i < CHANNELS; i++) begin
        live_tbl[i] = '0;
        fs_tbl[i]   = '0;
      end
      err_cnt       = 0;
      result_cnt    = 0;
      word_cnt      = 0;
      fs_result_cnt = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [15:0] data);
      if (idx == rcsfd_pkg::CFG_MODE_2048) begin
        mode_2048 = data[0];
      end else if (idx == rcsfd_pkg::CFG_FS_TIMEOUT) begin
        timeout_ms = data;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the predictor by one accepted input transfer
    function void note_item(logic [1:0] fn, logic [7:0] rx, logic start, logic [3:0] ch,
                            logic [rcsfd_pkg::PosW-1:0] fsv);
      decoder_out_t               res;
      logic [15:0]                word;
      logic [rcsfd_pkg::IdW-1:0]  id;
      logic [rcsfd_pkg::PosW-1:0] pos;
      int unsigned                p;
      logic                       fs;
      res.query_value = '0;
      res.word        = '0;
      if (fn == rcsfd_pkg::FUNC_BYTE) begin
        if (start) begin
          byte_pos = 0;
        end
        p = byte_pos;
        if (p % 2 == 0) begin
          high_byte = rx;
        end else if (p != 1) begin
          // Split the big-endian word by field mode
          word = {high_byte, rx};
          if (mode_2048) begin
            id  = word[14:11];
            pos = word[10:0];
          end else begin
            id  = word[13:10];
            pos = {1'b0, word[9:0]};
          end
          if (id < CHANNELS) begin
            live_tbl[id]     = pos;
            res.word.valid   = 1'b1;
            res.word.channel = id;
            res.word.value   = pos;
          end
        end
        // Close the frame and restart the loss timer
        if (p + 1 >= FRAME_BYTES) begin
          byte_pos = 0;
          ms_since = '0;
        end else begin
          byte_pos = p + 1;
        end
      end else if (fn == rcsfd_pkg::FUNC_TICK) begin
        if (ms_since != rcsfd_pkg::MsReset) begin
          ms_since = ms_since + 16'd1;
        end
      end else if (fn == rcsfd_pkg::FUNC_FS_WRITE) begin
        if (ch < CHANNELS) begin
          fs_tbl[ch] = fsv;
        end
      end
      fs = (ms_since > timeout_ms);
      if (ch < CHANNELS) begin
        res.query_value = fs ? fs_tbl[ch] : live_tbl[ch];
      end
      res.failsafe_active = fs;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        err_cnt++;
      end
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic [31:0] tdata, logic [1:0] tuser);
      decoder_out_t exp_out;
      result_cnt++;
      if (expected_q.size() == 0) begin
        $error("result transfer with no expected result pending");
        err_cnt++;
        return;
      end
      exp_out = expected_q.pop_front();
      if (exp_out.word.valid) begin
        word_cnt++;
      end
      if (exp_out.failsafe_active) begin
        fs_result_cnt++;
      end
      compare_field("query_value", 16'(exp_out.query_value), 16'(tdata[10:0]));
      compare_field("word_channel", 16'(exp_out.word.channel), 16'(tdata[14:11]));
      compare_field("word_value", 16'(exp_out.word.value), 16'(tdata[25:15]));
      compare_field("failsafe_active", 16'(exp_out.failsafe_active), 16'(tuser[0]));
      compare_field("word_valid", 16'(exp_out.word.valid), 16'(tuser[1]));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block instance
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: rx_byte[7:0], channel_index[11:8], failsafe_value[22:12], zero pad
  logic [23:0] s_axis_tdata  = '0;
  // tuser: func[1:0], frame_start[2]
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: query_value[10:0], word_channel[14:11], word_value[25:15], zero pad
  logic [31:0] m_axis_tdata;
  // tuser: failsafe_active[0], word_valid[1]
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  frame_scoreboard board = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned item_cnt      = 0;
  int unsigned settings_cnt  = 1;

  rc_satellite_frame_decoder #(
    .FRAME_BYTES(FRAME_BYTES),
    .CHANNELS   (CHANNELS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock
  always begin
    #ClkHigh clk_i = 1'b1;
    #ClkLow clk_i = 1'b0;
  end

  // Check result transfers and stall the result side at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_result(m_axis_tdata, m_axis_tuser);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one input item and hold it until the transfer; tvalid stays high
  task automatic send_item(input logic [1:0] fn, input logic [7:0] rx, input logic start,
                           input logic [3:0] ch, input logic [rcsfd_pkg::PosW-1:0] fsv);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, fsv, ch, rx};
    s_axis_tuser  <= {start, fn};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(fn, rx, start, ch, fsv);
    item_cnt++;
  endtask

  // Drop tvalid and wait until every expected result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write both registers back to back; valid stays high between them
  task automatic write_settings(input logic mode, input logic [15:0] timeout);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= rcsfd_pkg::CFG_MODE_2048;
    cfg_data_i  <= {15'd0, mode};
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(rcsfd_pkg::CFG_MODE_2048, {15'd0, mode});
    cfg_index_i <= rcsfd_pkg::CFG_FS_TIMEOUT;
    cfg_data_i  <= timeout;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(rcsfd_pkg::CFG_FS_TIMEOUT, timeout);
    cfg_valid_i <= 1'b0;
    settings_cnt++;
  endtask

  // Send a run of bytes; a full-length run whose first byte carries the frame flag is a well-formed frame
  task automatic send_frame(input int unsigned len);
    logic start;
    for (int i = 0; i < len; i++) begin
      start = (i == 0) && ($urandom_range(0, 99) < 85);
      send_item(rcsfd_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)), start,
                4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)));
    end
  endtask

  // Pick one random sequence, mostly whole frames and tick bursts
  task automatic send_random_sequence();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_frame(FRAME_BYTES);
    end else if (pick < 62) begin
      send_frame($urandom_range(1, FRAME_BYTES - 1));
    end else if (pick < 77) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      repeat (n) begin
        send_item(rcsfd_pkg::FUNC_TICK, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                  11'($urandom_range(0, 2047)));
      end
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(rcsfd_pkg::FUNC_FS_WRITE, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                  11'($urandom_range(0, 2047)));
      end
    end else if (pick < 95) begin
      // Stray bytes with stray frame flags
      repeat ($urandom_range(1, 6)) begin
        send_item(rcsfd_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)),
                  ($urandom_range(0, 3) == 0), 4'($urandom_range(0, 15)),
                  11'($urandom_range(0, 2047)));
      end
    end else begin
      send_item(FuncUnused, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)));
    end
  endtask

  // Directed items at the reset settings
  task automatic run_directed();
    logic [15:0] word;
    // Tick with the loss timer already saturated, then an unused code
    send_item(rcsfd_pkg::FUNC_TICK, 8'h00, 1'b0, 4'd0, 11'd0);
    send_item(FuncUnused, 8'hFF, 1'b1, 4'd15, 11'd2047);
    // Failsafe entries at the value extremes
    send_item(rcsfd_pkg::FUNC_FS_WRITE, 8'h00, 1'b0, 4'd15, 11'd2047);
    send_item(rcsfd_pkg::FUNC_FS_WRITE, 8'hFF, 1'b0, 4'd0, 11'd0);
    send_item(rcsfd_pkg::FUNC_FS_WRITE, 8'h5A, 1'b0, 4'd7, 11'd1365);
    // Bytes before any frame flag decode as if a frame began at reset
    send_item(rcsfd_pkg::FUNC_BYTE, 8'hFF, 1'b0, 4'd15, 11'd0);
    send_item(rcsfd_pkg::FUNC_BYTE, 8'hFF, 1'b0, 4'd15, 11'd0);
    send_item(rcsfd_pkg::FUNC_BYTE, 8'h7F, 1'b0, 4'd15, 11'd0);
    send_item(rcsfd_pkg::FUNC_BYTE, 8'hFF, 1'b0, 4'd15, 11'd0);
    send_item(rcsfd_pkg::FUNC_BYTE, 8'h00, 1'b0, 4'd0, 11'd0);
    send_item(rcsfd_pkg::FUNC_BYTE, 8'h00, 1'b0, 4'd0, 11'd0);
    // A flagged frame restarts mid-run and completes, leaving failsafe
    for (int i = 0; i < FRAME_BYTES; i++) begin
      case (i / 2)
        0:       word = 16'h03B2;
        1:       word = 16'h07FF;
        2:       word = 16'h7800;
        3:       word = 16'h4155;
        4:       word = 16'h2AAA;
        5:       word = 16'h0001;
        6:       word = 16'hFFFF;
        default: word = 16'h8000;
      endcase
      send_item(rcsfd_pkg::FUNC_BYTE, (i % 2 == 0) ? word[15:8] : word[7:0], (i == 0),
                i[3:0], 11'd2047);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned target;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 0) begin
        run_directed();
      end else begin
        drain_results();
        case (ph)
          1:       write_settings(1'b0, 16'd0);
          2:       write_settings(1'b1, 16'hFFFF);
          3:       write_settings(1'b0, 16'($urandom_range(2, 40)));
          4:       write_settings(1'b1, 16'($urandom_range(2, 40)));
          default: write_settings(1'b1, 16'd0);
        endcase
      end
      target = item_cnt + PhaseItems;
      while (item_cnt < target) send_random_sequence();
    end

    drain_results();
    $display("Run covered %0d input items and %0d results over %0d register settings",
             item_cnt, board.result_cnt, settings_cnt);
    $display("  including %0d decoded servo words and %0d results under failsafe",
             board.word_cnt, board.fs_result_cnt);
    if (board.err_cnt == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rcsfd_pkg.sv
hw/rtl/rcsfd_word_dec.sv
hw/rtl/rc_satellite_frame_decoder.sv
bench/rc_satellite_frame_decoder_tb.sv
